### src/dsd_pkg.sv
package dsd_pkg;

	localparam int MAX_BUFFER    = 4096;
	localparam int MAX_INTEGERS  = 8;
	localparam int MAX_LEN_BYTES = 8;

	localparam int LEN_W     = 13;
	localparam int CNT_W     = 4;
	localparam int IDX_W     = 3;
	localparam int LCNT_W    = 7;
	localparam int CFG_IDX_W = 1;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [7:0] TAG_SEQ = 8'h30;
	localparam logic [7:0] TAG_INT = 8'h02;

	localparam logic [LEN_W-1:0] BUF_LIM_MAX = LEN_W'(MAX_BUFFER);
	localparam logic [CNT_W-1:0] INT_LIM_MAX = CNT_W'(MAX_INTEGERS);
	localparam logic [CNT_W-1:0] INT_LIM_RST = CNT_W'(2);
	localparam logic [LCNT_W-1:0] LCNT_MAX   = LCNT_W'(MAX_LEN_BYTES);
	localparam logic [LEN_W-1:0] ACC_MAX     = {LEN_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LENGTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEGER_COUNT = 1'b1;

	typedef enum logic [2:0] {
		ST_PROGRESS,
		ST_DONE,
		ST_BAD_SEQ_TAG,
		ST_BAD_INT_TAG,
		ST_LEN_TOO_LONG,
		ST_PAST_END,
		ST_EARLY_END
	} dsd_status_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_SEQ_TAG,
		PH_SEQ_LEN,
		PH_SEQ_LEN_MORE,
		PH_INT_TAG,
		PH_INT_LEN,
		PH_INT_LEN_MORE,
		PH_VALUE,
		PH_FINISHED
	} dsd_phase_t;

	typedef struct packed {
		logic [7:0]        data_byte;
		logic              first_byte;
		logic              is_seq_tag;
		logic              is_int_tag;
		logic              is_zero;
		logic              long_form;
		logic [LCNT_W-1:0] len_cnt;
		logic              cnt_too_long;
	} dsd_item_t;

	typedef struct packed {
		logic [LEN_W-1:0] buf_lim;
		logic [CNT_W-1:0] int_lim;
	} dsd_cfg_t;

	typedef struct packed {
		logic [7:0]       value_byte;
		logic             has_byte;
		logic [IDX_W-1:0] integer_index;
		logic [LEN_W-1:0] bytes_left;
		logic             integer_last;
		dsd_status_t      status;
	} dsd_result_t;

endpackage

### src/dsd_if.sv
interface dsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;

	modport source (output valid, output data_byte, output first_byte, input ready);
	modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface dsd_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  value_byte;
	logic        has_byte;
	logic [2:0]  integer_index;
	logic [12:0] bytes_left;
	logic        integer_last;
	logic [2:0]  status;

	modport source (output valid, output value_byte, output has_byte, output integer_index,
		output bytes_left, output integer_last, output status, input ready);
	modport sink (input valid, input value_byte, input has_byte, input integer_index,
		input bytes_left, input integer_last, input status, output ready);
endinterface

interface dsd_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [12:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

### src/dsd_front.sv
module dsd_front (
	input  logic              clk,
	input  logic              arst_n,
	dsd_in_if.sink            data,
	output dsd_pkg::dsd_item_t item,
	output logic              item_valid,
	input  logic              item_ready
);
	import dsd_pkg::*;

	logic      v_s1;
	dsd_item_t item_s1;
	dsd_item_t cls;
	logic      accept;

	assign data.ready = !v_s1 || item_ready;
	assign accept     = data.valid && data.ready;

	// classify the byte
	always_comb begin
		cls.data_byte    = data.data_byte;
		cls.first_byte   = data.first_byte;
		cls.is_seq_tag   = data.data_byte == TAG_SEQ;
		cls.is_int_tag   = data.data_byte == TAG_INT;
		cls.is_zero      = data.data_byte == 8'h00;
		cls.long_form    = data.data_byte[7];
		cls.len_cnt      = data.data_byte[LCNT_W-1:0];
		cls.cnt_too_long = data.data_byte[LCNT_W-1:0] > LCNT_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (item_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= cls;
		end
	end

	assign item       = item_s1;
	assign item_valid = v_s1;
endmodule

### src/dsd_queue.sv
module dsd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  dsd_pkg::dsd_item_t push_item,
	input  logic               push_valid,
	output logic               push_ready,
	output dsd_pkg::dsd_item_t head_item,
	output logic               head_valid,
	input  logic               pop
);
	import dsd_pkg::*;

	dsd_item_t         slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = count_q != QCNT_W'(QDEPTH);
	assign head_valid = count_q != '0;
	assign head_item  = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_item;
		end
	end
endmodule

### src/dsd_back.sv
module dsd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  dsd_pkg::dsd_cfg_t  cfg_lim,
	input  dsd_pkg::dsd_item_t item,
	input  logic               item_valid,
	output logic               pop,
	dsd_out_if.source          result
);
	import dsd_pkg::*;

	dsd_phase_t       phase_q;
	logic [CNT_W-1:0] cur_q;
	logic [CNT_W-1:0] lbp_q;
	logic [LEN_W-1:0] acc_q;
	logic [LEN_W-1:0] vbp_q;
	logic             strip_q;
	logic [LEN_W-1:0] pos_q;

	dsd_phase_t       ph;
	logic [CNT_W-1:0] cur;
	logic [CNT_W-1:0] lbp;
	logic [LEN_W-1:0] acc;
	logic [LEN_W-1:0] vbp;
	logic             strip;
	logic [LEN_W-1:0] pos;
	logic [LEN_W-1:0] pos_inc;

	dsd_phase_t       nph;
	logic [CNT_W-1:0] ncur;
	logic [CNT_W-1:0] nlbp;
	logic [LEN_W-1:0] nacc;
	logic [LEN_W-1:0] nvbp;
	logic             nstrip;
	logic [LEN_W-1:0] npos;

	logic [LEN_W-1:0] rem;
	logic             at_end;
	logic             len_fin;
	logic             fin_int;
	logic             emit;
	dsd_status_t      st;
	dsd_result_t      res;

	dsd_result_t      res_q;
	logic             res_valid_q;

	assign pop = item_valid && (!res_valid_q || result.ready);

	always_comb begin
		ph      = item.first_byte ? PH_SEQ_TAG : phase_q;
		cur     = item.first_byte ? '0 : cur_q;
		lbp     = item.first_byte ? '0 : lbp_q;
		acc     = item.first_byte ? '0 : acc_q;
		vbp     = item.first_byte ? '0 : vbp_q;
		strip   = item.first_byte ? 1'b0 : strip_q;
		pos     = item.first_byte ? '0 : pos_q;
		pos_inc = pos + 1'b1;

		nph     = ph;
		ncur    = cur;
		nlbp    = lbp;
		nacc    = acc;
		nvbp    = vbp;
		nstrip  = strip;
		npos    = pos;
		rem     = (cfg_lim.buf_lim > pos_inc) ? cfg_lim.buf_lim - pos_inc : '0;
		at_end  = pos_inc >= cfg_lim.buf_lim;
		len_fin = 1'b0;
		fin_int = 1'b0;
		emit    = 1'b0;
		st      = ST_PROGRESS;
		res     = '0;
		res.integer_index = cur[IDX_W-1:0];

		if (ph != PH_IDLE && ph != PH_FINISHED) begin
			npos = pos_inc;
			case (ph)
				PH_SEQ_TAG: begin
					if (!item.is_seq_tag) st = ST_BAD_SEQ_TAG;
					else nph = PH_SEQ_LEN;
				end
				PH_INT_TAG: begin
					if (!item.is_int_tag) st = ST_BAD_INT_TAG;
					else nph = PH_INT_LEN;
				end
				PH_SEQ_LEN, PH_INT_LEN: begin
					nacc = '0;
					nlbp = '0;
					if (!item.long_form) begin
						nacc    = LEN_W'(item.data_byte);
						len_fin = 1'b1;
					end else if (item.cnt_too_long) begin
						st = ST_LEN_TOO_LONG;
					end else if (LEN_W'(item.len_cnt) > rem) begin
						st = ST_PAST_END;
					end else if (item.len_cnt == '0) begin
						len_fin = 1'b1;
					end else begin
						nlbp = item.len_cnt[CNT_W-1:0];
						nph  = (ph == PH_SEQ_LEN) ? PH_SEQ_LEN_MORE : PH_INT_LEN_MORE;
					end
				end
				PH_SEQ_LEN_MORE, PH_INT_LEN_MORE: begin
					// saturates once the upper byte would overflow
					if (acc[LEN_W-1:LEN_W-8] != '0) nacc = ACC_MAX;
					else nacc = {acc[LEN_W-9:0], item.data_byte};
					nlbp = lbp - 1'b1;
					if (lbp == CNT_W'(1)) len_fin = 1'b1;
				end
				PH_VALUE: begin
					if (strip && item.is_zero && vbp > LEN_W'(1)) begin
						nvbp = vbp - 1'b1;
					end else begin
						nstrip           = 1'b0;
						emit             = 1'b1;
						res.value_byte   = item.data_byte;
						res.has_byte     = 1'b1;
						res.bytes_left   = vbp;
						res.integer_last = vbp == LEN_W'(1);
						nvbp             = vbp - 1'b1;
						if (vbp == LEN_W'(1)) fin_int = 1'b1;
					end
				end
				default: begin
					st = ST_PROGRESS;
				end
			endcase

			if (len_fin) begin
				if (nacc > rem) begin
					st = ST_PAST_END;
				end else if (ph == PH_SEQ_LEN || ph == PH_SEQ_LEN_MORE) begin
					nph = PH_INT_TAG;
				end else if (nacc == '0) begin
					emit             = 1'b1;
					res.integer_last = 1'b1;
					fin_int          = 1'b1;
				end else begin
					nvbp   = nacc;
					nstrip = 1'b1;
					nph    = PH_VALUE;
				end
			end

			if (fin_int) begin
				ncur = cur + 1'b1;
				if (ncur >= cfg_lim.int_lim) st = ST_DONE;
				else nph = PH_INT_TAG;
			end

			if (st == ST_PROGRESS && at_end) st = ST_EARLY_END;
			if (st != ST_PROGRESS) begin
				nph  = PH_FINISHED;
				emit = 1'b1;
			end
		end
		res.status = st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cur_q       <= '0;
			lbp_q       <= '0;
			acc_q       <= '0;
			vbp_q       <= '0;
			strip_q     <= 1'b0;
			pos_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= nph;
				cur_q   <= ncur;
				lbp_q   <= nlbp;
				acc_q   <= nacc;
				vbp_q   <= nvbp;
				strip_q <= nstrip;
				pos_q   <= npos;
			end
			if (pop && emit) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			res_q <= res;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.value_byte    = res_q.value_byte;
	assign result.has_byte      = res_q.has_byte;
	assign result.integer_index = res_q.integer_index;
	assign result.bytes_left    = res_q.bytes_left;
	assign result.integer_last  = res_q.integer_last;
	assign result.status        = res_q.status;
endmodule

### src/der_integer_sequence_decoder_top.sv
// channel  | modport | payload                                           | accepted when
// data     | sink    | data_byte, first_byte                             | valid && ready
// result   | source  | value_byte, has_byte, integer_index, bytes_left,  | valid && ready
//          |         | integer_last, status                              |
// cfg      | sink    | index, wdata                                      | valid && ready
//
// one byte per cycle sustained while the result side is not stalled; a taken byte reaches the result
// through the front register, the queue and the back output register
// the back parser updates all state for a byte as it pops it, so bytes stream back to back
// arst_n clears the parser to idle, empties the queue and loads the register defaults
// a stalled result holds the back, the four-entry queue absorbs the front meanwhile
// cfg is always ready and takes effect from the next byte the back parser takes
module der_integer_sequence_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	dsd_in_if.sink     data,
	dsd_out_if.source  result,
	dsd_cfg_if.sink    cfg
);
	import dsd_pkg::*;

	dsd_cfg_t   cfg_lim_q;
	dsd_item_t  front_item;
	logic       front_valid;
	logic       q_ready;
	dsd_item_t  head_item;
	logic       head_valid;
	logic       back_pop;
	logic [CNT_W-1:0] cnt_w;

	assign cfg.ready = 1'b1;
	assign cnt_w     = cfg.wdata[CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_lim_q.buf_lim <= BUF_LIM_MAX;
			cfg_lim_q.int_lim <= INT_LIM_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_BUFFER_LENGTH: begin
					cfg_lim_q.buf_lim <= (cfg.wdata > BUF_LIM_MAX) ? BUF_LIM_MAX : cfg.wdata;
				end
				CFG_INTEGER_COUNT: begin
					if (cnt_w == '0) cfg_lim_q.int_lim <= CNT_W'(1);
					else if (cnt_w > INT_LIM_MAX) cfg_lim_q.int_lim <= INT_LIM_MAX;
					else cfg_lim_q.int_lim <= cnt_w;
				end
				default: begin
					cfg_lim_q <= cfg_lim_q;
				end
			endcase
		end
	end

	dsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data       (data),
		.item       (front_item),
		.item_valid (front_valid),
		.item_ready (q_ready)
	);

	dsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (front_item),
		.push_valid (front_valid),
		.push_ready (q_ready),
		.head_item  (head_item),
		.head_valid (head_valid),
		.pop        (back_pop)
	);

	dsd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_lim    (cfg_lim_q),
		.item       (head_item),
		.item_valid (head_valid),
		.pop        (back_pop),
		.result     (result)
	);
endmodule

### src/dsd_checker.sv
module dsd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [7:0]  value_byte,
	input logic        has_byte,
	input logic [12:0] bytes_left,
	input logic        integer_last,
	input logic [2:0]  status
);
	import dsd_pkg::*;

	// a stalled transaction keeps its value byte, bytes left and status
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(value_byte) && $stable(bytes_left)
		&& $stable(status))
		else $error("result changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !has_byte |-> value_byte == 8'h00 && bytes_left == '0)
		else $error("result without byte carries data");

	a_last_one: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && has_byte |-> bytes_left != '0 && (integer_last == (bytes_left == 13'd1)))
		else $error("bytes_left and integer_last disagree");

	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !has_byte && !integer_last |-> status != ST_PROGRESS && status != ST_DONE)
		else $error("status-only result without an error");
endmodule

bind der_integer_sequence_decoder_top dsd_checker u_dsd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.value_byte   (result.value_byte),
	.has_byte     (result.has_byte),
	.bytes_left   (result.bytes_left),
	.integer_last (result.integer_last),
	.status       (result.status)
);

### bench/der_integer_sequence_decoder_top_tb.sv
`timescale 1ns / 1ps

module der_integer_sequence_decoder_top_tb;
	import dsd_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 16;

	typedef enum int {GAP_NONE, GAP_SRC, GAP_SNK, GAP_BOTH} gap_mode_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} der_byte_t;

	typedef logic [7:0] byte_list_t[$];

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic       in_valid = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       in_first = 1'b0;
	logic       in_taken = 1'b0;
	logic       out_ready = 1'b0;

	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int errors = 0;
	int cycle_count = 0;
	int items_queued = 0;
	int items_taken = 0;
	int results_seen = 0;

	der_byte_t   byte_feed_q[$];
	dsd_result_t decoded_q[$];

	// decoder shadow state
	logic [LEN_W-1:0] reg_buf_len = BUF_LIM_MAX;
	logic [CNT_W-1:0] reg_int_cnt = INT_LIM_RST;
	dsd_phase_t       mdl_phase = PH_IDLE;
	logic [LEN_W-1:0] mdl_pos = '0;
	logic [CNT_W-1:0] mdl_int = '0;
	logic [CNT_W-1:0] mdl_lpend = '0;
	logic [LEN_W-1:0] mdl_acc = '0;
	logic [LEN_W-1:0] mdl_vpend = '0;
	logic             mdl_strip = 1'b0;
	dsd_result_t      pend_res;
	logic             pend_valid;

	dsd_in_if  data_ch();
	dsd_out_if result_ch();
	dsd_cfg_if cfg_ch();

	assign data_ch.valid      = in_valid;
	assign data_ch.data_byte  = in_byte;
	assign data_ch.first_byte = in_first;
	assign result_ch.ready    = out_ready;

	der_integer_sequence_decoder_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.data   (data_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [LEN_W-1:0] buf_limit();
		return (reg_buf_len > BUF_LIM_MAX) ? BUF_LIM_MAX : reg_buf_len;
	endfunction

	function automatic logic [CNT_W-1:0] int_limit();
		if (reg_int_cnt == '0) return CNT_W'(1);
		return (reg_int_cnt > INT_LIM_MAX) ? INT_LIM_MAX : reg_int_cnt;
	endfunction

	function automatic void emit_result(logic [7:0] vb, logic has, logic [LEN_W-1:0] left,
		logic last);
		pend_valid = 1'b1;
		pend_res.value_byte = vb;
		pend_res.has_byte = has;
		pend_res.integer_index = mdl_int[IDX_W-1:0];
		pend_res.bytes_left = left;
		pend_res.integer_last = last;
	endfunction

	function automatic dsd_status_t close_integer();
		mdl_int = mdl_int + 1'b1;
		if (mdl_int >= int_limit()) return ST_DONE;
		mdl_phase = PH_INT_TAG;
		return ST_PROGRESS;
	endfunction

	function automatic dsd_status_t length_complete(logic [LEN_W-1:0] rem);
		if (mdl_acc > rem) return ST_PAST_END;
		if (mdl_phase == PH_SEQ_LEN || mdl_phase == PH_SEQ_LEN_MORE) begin
			mdl_phase = PH_INT_TAG;
			return ST_PROGRESS;
		end
		if (mdl_acc == '0) begin
			emit_result(8'h00, 1'b0, '0, 1'b1);
			return close_integer();
		end
		mdl_vpend = mdl_acc;
		mdl_strip = 1'b1;
		mdl_phase = PH_VALUE;
		return ST_PROGRESS;
	endfunction

	task automatic decode_der_byte(logic [7:0] b, logic first);
		dsd_status_t      st;
		logic [LEN_W-1:0] lim;
		logic [LEN_W-1:0] rem;
		int               acc_next;
		st = ST_PROGRESS;
		pend_res = '0;
		pend_valid = 1'b0;
		if (first) begin
			mdl_phase = PH_SEQ_TAG;
			mdl_pos = '0;
			mdl_int = '0;
			mdl_lpend = '0;
			mdl_acc = '0;
			mdl_vpend = '0;
			mdl_strip = 1'b0;
		end
		if (mdl_phase == PH_IDLE || mdl_phase == PH_FINISHED) return;
		mdl_pos = mdl_pos + 1'b1;
		lim = buf_limit();
		rem = (lim > mdl_pos) ? lim - mdl_pos : '0;
		case (mdl_phase)
			PH_SEQ_TAG: begin
				if (b != TAG_SEQ) st = ST_BAD_SEQ_TAG;
				else mdl_phase = PH_SEQ_LEN;
			end
			PH_INT_TAG: begin
				if (b != TAG_INT) st = ST_BAD_INT_TAG;
				else mdl_phase = PH_INT_LEN;
			end
			PH_SEQ_LEN, PH_INT_LEN: begin
				mdl_acc = '0;
				mdl_lpend = '0;
				if (!b[7]) begin
					mdl_acc = LEN_W'(b);
					st = length_complete(rem);
				end else if (b[6:0] > LCNT_MAX) begin
					st = ST_LEN_TOO_LONG;
				end else if (LEN_W'(b[6:0]) > rem) begin
					st = ST_PAST_END;
				end else if (b[6:0] == '0) begin
					st = length_complete(rem);
				end else begin
					mdl_lpend = CNT_W'(b[6:0]);
					mdl_phase = (mdl_phase == PH_SEQ_LEN) ? PH_SEQ_LEN_MORE : PH_INT_LEN_MORE;
				end
			end
			PH_SEQ_LEN_MORE, PH_INT_LEN_MORE: begin
				acc_next = int'(mdl_acc) * 256 + int'(b);
				mdl_acc = (acc_next > int'(ACC_MAX)) ? ACC_MAX : LEN_W'(acc_next);
				mdl_lpend = mdl_lpend - 1'b1;
				if (mdl_lpend == '0) st = length_complete(rem);
			end
			default: begin
				if (mdl_strip && b == 8'h00 && mdl_vpend > 1) begin
					mdl_vpend = mdl_vpend - 1'b1;
				end else begin
					mdl_strip = 1'b0;
					emit_result(b, 1'b1, mdl_vpend, mdl_vpend == 1);
					mdl_vpend = mdl_vpend - 1'b1;
					if (mdl_vpend == '0) st = close_integer();
				end
			end
		endcase
		if (st == ST_PROGRESS && mdl_pos >= lim) st = ST_EARLY_END;
		if (st != ST_PROGRESS) begin
			mdl_phase = PH_FINISHED;
			if (!pend_valid) emit_result(8'h00, 1'b0, '0, 1'b0);
		end
		if (pend_valid) begin
			pend_res.status = st;
			decoded_q.push_back(pend_res);
		end
	endtask

	function automatic void note_error(string msg);
		if (errors < 10) $display("%s", msg);
		errors++;
	endfunction

	always @(negedge clk) begin : drive
		der_byte_t nxt;
		logic      nv;
		nv = in_valid;
		if (!in_valid || in_taken) begin
			nv = 1'b0;
			if (byte_feed_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				nxt = byte_feed_q.pop_front();
				in_byte <= nxt.data_byte;
				in_first <= nxt.first_byte;
				nv = 1'b1;
			end
		end
		in_valid <= nv;
		out_ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	always @(posedge clk) begin : monitor
		dsd_result_t seen;
		dsd_result_t want;
		cycle_count <= cycle_count + 1;
		in_taken <= in_valid && data_ch.ready;
		if (result_ch.valid === 1'b1 && out_ready) begin
			seen.value_byte = result_ch.value_byte;
			seen.has_byte = result_ch.has_byte;
			seen.integer_index = result_ch.integer_index;
			seen.bytes_left = result_ch.bytes_left;
			seen.integer_last = result_ch.integer_last;
			seen.status = dsd_status_t'(result_ch.status);
			if (decoded_q.size() == 0) begin
				note_error($sformatf("result %0d with nothing expected: byte=%h st=%0d",
					results_seen, seen.value_byte, seen.status));
			end else begin
				want = decoded_q.pop_front();
				if (seen !== want)
					note_error($sformatf({"result %0d mismatch: expected byte=%h has=%b idx=%0d ",
						"left=%0d last=%b st=%0d, got byte=%h has=%b idx=%0d left=%0d last=%b ",
						"st=%0d"}, results_seen,
						want.value_byte, want.has_byte, want.integer_index, want.bytes_left,
						want.integer_last, want.status,
						seen.value_byte, seen.has_byte, seen.integer_index, seen.bytes_left,
						seen.integer_last, seen.status));
			end
			results_seen++;
		end
		if (in_valid && data_ch.ready) begin
			decode_der_byte(in_byte, in_first);
			items_taken++;
		end
	end

	function automatic void queue_item(logic [7:0] b, logic first);
		der_byte_t it;
		it.data_byte = b;
		it.first_byte = first;
		byte_feed_q.push_back(it);
		items_queued++;
	endfunction

	function automatic byte_list_t length_field(int len);
		byte_list_t q;
		int         sel;
		int         k;
		sel = $urandom_range(9);
		if (len == 0 && sel == 0) begin
			q.push_back(8'h80);
		end else if (len < 128 && sel < 7) begin
			q.push_back(8'(len));
		end else if (len < 256 && sel < 9) begin
			q.push_back(8'h81);
			q.push_back(8'(len));
		end else begin
			k = $urandom_range(MAX_LEN_BYTES, 2);
			q.push_back(8'h80 | 8'(k));
			repeat (k - 2) q.push_back(8'h00);
			q.push_back(8'(len >> 8));
			q.push_back(8'(len));
		end
		return q;
	endfunction

	// one DER buffer, well formed unless corrupted or cut short at random
	function automatic int queue_buffer(int n_int);
		byte_list_t body;
		byte_list_t whole;
		byte_list_t lf;
		int         len;
		int         nz;
		int         r;
		int         cut;
		for (int i = 0; i < n_int; i++) begin
			r = $urandom_range(99);
			len = (r < 2) ? $urandom_range(300, 128) : (r < 10) ? $urandom_range(40) :
				$urandom_range(6);
			nz = ($urandom_range(2) == 0) ? $urandom_range(len) : 0;
			body.push_back(TAG_INT);
			lf = length_field(len);
			foreach (lf[j]) body.push_back(lf[j]);
			for (int j = 0; j < len; j++) body.push_back((j < nz) ? 8'h00 : 8'($urandom));
		end
		whole.push_back(TAG_SEQ);
		lf = length_field(body.size());
		foreach (lf[j]) whole.push_back(lf[j]);
		foreach (body[j]) whole.push_back(body[j]);
		repeat ($urandom_range(3)) whole.push_back(8'($urandom));
		if ($urandom_range(9) == 0) whole[$urandom_range(whole.size() - 1)] = 8'($urandom);
		if ($urandom_range(9) == 0) begin
			cut = $urandom_range(whole.size(), 1);
			while (whole.size() > cut) void'(whole.pop_back());
		end
		foreach (whole[j]) queue_item(whole[j], j == 0);
		return whole.size();
	endfunction

	task automatic settle();
		while (items_taken != items_queued || decoded_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= val;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		if (idx == CFG_BUFFER_LENGTH) reg_buf_len = val;
		else reg_int_cnt = val[CNT_W-1:0];
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_phase(int buf_len, int int_cnt, gap_mode_t mode, int n_items);
		int count;
		int eff;
		int r;
		settle();
		write_reg(CFG_BUFFER_LENGTH, LEN_W'(buf_len));
		write_reg(CFG_INTEGER_COUNT, {9'($urandom), CNT_W'(int_cnt)});
		src_idle_pct = (mode == GAP_SRC) ? 73 : (mode == GAP_BOTH) ? 8 : 0;
		snk_stall_pct = (mode == GAP_SNK) ? 73 : (mode == GAP_BOTH) ? 8 : 0;
		eff = int'(int_limit());
		count = 0;
		count += queue_buffer(eff);
		while (count < n_items) begin
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(4, 1))
					queue_item(8'($urandom), $urandom_range(9) < 3);
			end else begin
				r = $urandom_range(19);
				count += queue_buffer((r == 0) ? eff + 1 : (r == 1 && eff > 1) ? eff - 1 : eff);
			end
		end
	endtask

	initial begin : main
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_BUFFER_LENGTH;
		cfg_ch.wdata = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// idle byte, bad sequence tag, oversized length field
		queue_item(8'hAA, 1'b0);
		queue_item(8'h31, 1'b1);
		queue_item(TAG_SEQ, 1'b1);
		queue_item(8'hFF, 1'b0);
		// saturated length past the buffer end
		queue_item(TAG_SEQ, 1'b1);
		queue_item(8'h84, 1'b0);
		repeat (4) queue_item(8'hFF, 1'b0);
		// bad integer tag
		queue_item(TAG_SEQ, 1'b1);
		queue_item(8'h00, 1'b0);
		queue_item(8'h05, 1'b0);
		// abandoned parse, then empty integer and zero stripping
		queue_item(TAG_SEQ, 1'b1);
		queue_item(8'h05, 1'b0);
		queue_item(TAG_SEQ, 1'b1);
		queue_item(8'h80, 1'b0);
		queue_item(TAG_INT, 1'b0);
		queue_item(8'h80, 1'b0);
		queue_item(TAG_INT, 1'b0);
		queue_item(8'h03, 1'b0);
		queue_item(8'h00, 1'b0);
		queue_item(8'h00, 1'b0);
		queue_item(8'h80, 1'b0);

		run_phase(4096, 2, GAP_NONE, 150);
		run_phase(8191, 15, GAP_SRC, 150);
		run_phase(0, 0, GAP_SNK, 60);
		run_phase(1, 1, GAP_BOTH, 60);
		run_phase(24, 3, GAP_NONE, 150);
		run_phase(13, 8, GAP_SNK, 150);
		run_phase(4096, 8, GAP_SRC, 200);
		run_phase(300, 4, GAP_BOTH, 180);
		run_phase(100, 1, GAP_NONE, 150);
		run_phase(5000, 9, GAP_SNK, 200);
		settle();

		if (decoded_q.size() != 0)
			note_error($sformatf("%0d expected results never arrived", decoded_q.size()));
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

endmodule

### filelist.f
src/dsd_pkg.sv
src/dsd_if.sv
src/dsd_front.sv
src/dsd_queue.sv
src/dsd_back.sv
src/der_integer_sequence_decoder_top.sv
src/dsd_checker.sv
bench/der_integer_sequence_decoder_top_tb.sv
